/* rtl/core/coap_message_serializer_core_macros.svh */
// Assertion macros for the CoAP message serializer.
`ifndef COAP_MESSAGE_SERIALIZER_CORE_MACROS_SVH
`define COAP_MESSAGE_SERIALIZER_CORE_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define CSC_ASSERT_NOW(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("serializer check failed");

// Next-cycle implication, checked outside reset.
`define CSC_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("serializer check failed");

`endif

/* rtl/core/coapser_pkg.sv */
package coapser_pkg;

	typedef enum logic [1:0] {
		OP_HEADER = 2'd0,
		OP_OPTION = 2'd1,
		OP_DATA   = 2'd2,
		OP_MARK   = 2'd3
	} op_t;

	localparam int unsigned RunDepth = 5;
	localparam int unsigned IdxW     = 3;

	localparam logic [7:0]  HdrVersion  = 8'h40;
	localparam logic [7:0]  PayloadMark = 8'hFF;
	localparam logic [3:0]  Ext8Nibble  = 4'd13;
	localparam logic [3:0]  Ext16Nibble = 4'd14;
	localparam logic [15:0] Ext8Base    = 16'd13;
	localparam logic [15:0] Ext16Base   = 16'd269;

	typedef struct packed {
		logic [3:0] nib;
		logic [7:0] ext0;
		logic [7:0] ext1;
		logic [1:0] n;
	} nib_enc_t;

endpackage

/* rtl/core/coap_message_serializer_core.sv */
// CoAP message serializer core.
// Input channel (in_valid/in_ready) takes one item per beat: a header, an
// option start, a data byte or a payload marker. Output channel
// (out_valid/out_ready) gives one message byte per beat, with last_of_run
// on the final byte of each item and order_error on the single beat that
// flags a descending option number.
// Latency: the first byte of an item is offered the cycle after its beat.
// Item size: one byte for data and payload marker, four for a header, one
// to five for an option start. The run buffer holds one item's bytes; the
// next item is taken in the same cycle its last byte leaves, so data bytes
// stream one per clock while out_ready stays high.
// Reset clears the buffer-full flag, the byte index and the last option
// number; the block comes out of reset ready and with no output offered.
// When the receiver stalls, the offered byte holds and in_ready drops once
// the buffer is full and its last byte has not been taken.
module coap_message_serializer_core (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [1:0]  operation,
	input  logic [1:0]  message_type,
	input  logic [7:0]  message_code,
	input  logic [15:0] message_id,
	input  logic [3:0]  token_length,
	input  logic [15:0] option_number,
	input  logic [15:0] option_length,
	input  logic [7:0]  data_byte,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [7:0]  out_byte,
	output logic        last_of_run,
	output logic        order_error
);
	import coapser_pkg::*;

	function automatic nib_enc_t encode_nibble(input logic [15:0] v);
		nib_enc_t   e;
		logic [15:0] r8;
		logic [15:0] r16;
		r8  = v - Ext8Base;
		r16 = v - Ext16Base;
		e   = '0;
		if (v < Ext8Base) begin
			e.nib = v[3:0];
			e.n   = 2'd0;
		end else if (v < Ext16Base) begin
			e.nib  = Ext8Nibble;
			e.ext0 = r8[7:0];
			e.n    = 2'd1;
		end else begin
			e.nib  = Ext16Nibble;
			e.ext0 = r16[15:8];
			e.ext1 = r16[7:0];
			e.n    = 2'd2;
		end
		return e;
	endfunction

	logic [15:0]              last_opt_q;
	logic                     full_q;
	logic [IdxW-1:0]          idx_q;
	logic [RunDepth-1:0][7:0] bytes_s1;
	logic [IdxW-1:0]          last_idx_s1;
	logic                     err_s1;

	logic                     accept;
	logic                     done;
	logic [RunDepth-1:0][7:0] bytes_d;
	logic [IdxW-1:0]          last_idx_d;
	logic                     err_d;
	logic                     upd_opt;
	logic                     clr_opt;
	logic [15:0]              delta;
	nib_enc_t                 denc;
	nib_enc_t                 lenc;

	assign done     = full_q && out_ready && (idx_q == last_idx_s1);
	assign in_ready = !full_q || done;
	assign accept   = in_valid && in_ready;

	assign delta = option_number - last_opt_q;
	assign denc  = encode_nibble(delta);
	assign lenc  = encode_nibble(option_length);

	always_comb begin
		bytes_d    = '0;
		last_idx_d = '0;
		err_d      = 1'b0;
		upd_opt    = 1'b0;
		clr_opt    = 1'b0;
		case (op_t'(operation))
			OP_HEADER: begin
				bytes_d[0] = HdrVersion | {2'b00, message_type, token_length};
				bytes_d[1] = message_code;
				bytes_d[2] = message_id[15:8];
				bytes_d[3] = message_id[7:0];
				last_idx_d = IdxW'(3);
				clr_opt    = 1'b1;
			end
			OP_OPTION: begin
				if (option_number < last_opt_q) begin
					err_d = 1'b1;
				end else begin
					upd_opt    = 1'b1;
					bytes_d[0] = {denc.nib, lenc.nib};
					last_idx_d = IdxW'(denc.n) + IdxW'(lenc.n);
					case (denc.n)
						2'd0: begin
							bytes_d[1] = lenc.ext0;
							bytes_d[2] = lenc.ext1;
						end
						2'd1: begin
							bytes_d[1] = denc.ext0;
							bytes_d[2] = lenc.ext0;
							bytes_d[3] = lenc.ext1;
						end
						default: begin
							bytes_d[1] = denc.ext0;
							bytes_d[2] = denc.ext1;
							bytes_d[3] = lenc.ext0;
							bytes_d[4] = lenc.ext1;
						end
					endcase
				end
			end
			OP_DATA: begin
				bytes_d[0] = data_byte;
			end
			default: begin
				bytes_d[0] = PayloadMark;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			full_q     <= 1'b0;
			idx_q      <= '0;
			last_opt_q <= '0;
		end else begin
			if (accept) begin
				full_q <= 1'b1;
				idx_q  <= '0;
				if (clr_opt) begin
					last_opt_q <= '0;
				end else if (upd_opt) begin
					last_opt_q <= option_number;
				end
			end else if (done) begin
				full_q <= 1'b0;
			end else if (full_q && out_ready) begin
				idx_q <= idx_q + IdxW'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			bytes_s1    <= bytes_d;
			last_idx_s1 <= last_idx_d;
			err_s1      <= err_d;
		end
	end

	assign out_valid   = full_q;
	assign out_byte    = bytes_s1[idx_q];
	assign last_of_run = (idx_q == last_idx_s1);
	assign order_error = err_s1;

endmodule

/* rtl/core/coapser_checker.sv */
`include "coap_message_serializer_core_macros.svh"

module coapser_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        in_valid,
	input logic        in_ready,
	input logic [1:0]  operation,
	input logic [7:0]  data_byte,
	input logic        out_valid,
	input logic        out_ready,
	input logic [7:0]  out_byte,
	input logic        last_of_run,
	input logic        order_error
);
	import coapser_pkg::*;

	`CSC_ASSERT_NEXT(a_out_hold, clk, arst_n, out_valid && !out_ready,
		out_valid && $stable(out_byte) && $stable(last_of_run))

	`CSC_ASSERT_NOW(a_err_beat, clk, arst_n, out_valid && order_error,
		last_of_run && (out_byte == 8'h00))

	`CSC_ASSERT_NOW(a_busy, clk, arst_n, !in_ready, out_valid)

	`CSC_ASSERT_NEXT(a_data_pass, clk, arst_n,
		in_valid && in_ready && (operation == OP_DATA),
		out_valid && last_of_run && !order_error && (out_byte == $past(data_byte)))

endmodule

bind coap_message_serializer_core coapser_checker u_coapser_checker (
	.clk         (clk),
	.arst_n      (arst_n),
	.in_valid    (in_valid),
	.in_ready    (in_ready),
	.operation   (operation),
	.data_byte   (data_byte),
	.out_valid   (out_valid),
	.out_ready   (out_ready),
	.out_byte    (out_byte),
	.last_of_run (last_of_run),
	.order_error (order_error)
);
